@@ rtl/vsa_pkg.sv @@
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared widths, operation and status codes, and controller/datapath types
// for the versioned snapshot array.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int SNAP_W   = 16;
    localparam int STATUS_W = 2;

    localparam int DEF_ENTRIES       = 64;
    localparam int DEF_HISTORY_DEPTH = 16;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SNAP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HIST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SNAP_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

    localparam logic [SNAP_W-1:0] SNAP_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        RES_OK,
        RES_SNAP,
        RES_READ,
        RES_HIST_FULL,
        RES_SNAP_FULL,
        RES_BAD_INDEX
    } res_kind_t;

    typedef enum logic [2:0] {
        HSEL_CLR,
        HSEL_NEWEST,
        HSEL_APPEND,
        HSEL_MID,
        HSEL_LO
    } hsel_t;

    typedef struct packed {
        logic [SNAP_W-1:0]  id;
        logic [VALUE_W-1:0] value;
    } hist_word_t;

    typedef struct packed {
        logic      load_req;
        logic      clr_wr;
        logic      cnt_rd;
        logic      cnt_inc;
        logic      hist_rd;
        logic      hist_wr;
        hsel_t     hist_sel;
        logic      search_init;
        logic      search_step;
        logic      out_load;
        res_kind_t out_kind;
    } vsa_cmd_t;

    typedef struct packed {
        logic              clr_last;
        logic [FUNC_W-1:0] func;
        logic              bad_index;
        logic              snap_full;
        logic              id_match;
        logic              hist_full;
        logic              search_done;
    } vsa_sts_t;

endpackage

@@ rtl/vsa_datapath.sv @@
// ----------------------------------------------------------------------------
// vsa_datapath
// Request registers, snapshot counter, per-entry fill counts, history memory,
// binary search bounds and result registers.
// ----------------------------------------------------------------------------
module vsa_datapath #(
    parameter int ENTRIES       = vsa_pkg::DEF_ENTRIES,
    parameter int HISTORY_DEPTH = vsa_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vsa_pkg::vsa_cmd_t                    cmd,
    output vsa_pkg::vsa_sts_t                    sts,
    input  logic [vsa_pkg::FUNC_W-1:0]           s_func,
    input  logic [vsa_pkg::INDEX_W-1:0]          s_entry_index,
    input  logic signed [vsa_pkg::VALUE_W-1:0]   s_write_value,
    input  logic [vsa_pkg::SNAP_W-1:0]           s_query_snapshot,
    output logic signed [vsa_pkg::VALUE_W-1:0]   m_read_value,
    output logic [vsa_pkg::SNAP_W-1:0]           m_taken_snapshot,
    output logic [vsa_pkg::STATUS_W-1:0]         m_status
);
    import vsa_pkg::*;

    localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_DEPTH = ENTRIES * HISTORY_DEPTH;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [FUNC_W-1:0]  req_func_reg;
    logic [INDEX_W-1:0] req_idx_reg;
    logic [VALUE_W-1:0] req_wval_reg;
    logic [SNAP_W-1:0]  req_query_reg;

    logic [SNAP_W-1:0]  current_reg;
    logic [ENT_AW-1:0]  clr_reg;

    logic [CNT_W-1:0]   cnt_mem [ENTRIES];
    logic [CNT_W-1:0]   cnt_q_reg;
    hist_word_t         hist_mem [MEM_DEPTH];
    hist_word_t         hist_q_reg;

    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   hi_reg;

    logic [VALUE_W-1:0] out_value_reg;
    logic [SNAP_W-1:0]  out_snap_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [ENT_AW+INDEX_W-1:0] idx_wide;
    logic [ENT_AW-1:0]  ent;
    logic [ADDR_W-1:0]  ent_base;
    logic [ADDR_W-1:0]  clr_base;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [IDX_W-1:0]   newest;
    logic [ADDR_W-1:0]  hist_addr;
    logic               cnt_we;
    logic [ENT_AW-1:0]  cnt_addr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic               hist_we;
    hist_word_t         hist_wdata;

    assign idx_wide = (ENT_AW + INDEX_W)'(req_idx_reg);
    assign ent      = idx_wide[ENT_AW-1:0];
    assign ent_base = ADDR_W'(ADDR_W'(ent) * ADDR_W'(HISTORY_DEPTH));
    assign clr_base = ADDR_W'(ADDR_W'(clr_reg) * ADDR_W'(HISTORY_DEPTH));
    assign mid_sum  = (IDX_W + 1)'(lo_reg) + (IDX_W + 1)'(hi_reg) + (IDX_W + 1)'(1);
    assign mid      = mid_sum[IDX_W:1];
    assign newest   = IDX_W'(cnt_q_reg - CNT_W'(1));

    always_comb begin
        case (cmd.hist_sel)
            HSEL_CLR:    hist_addr = clr_base;
            HSEL_NEWEST: hist_addr = ent_base + ADDR_W'(newest);
            HSEL_APPEND: hist_addr = ent_base + ADDR_W'(cnt_q_reg);
            HSEL_MID:    hist_addr = ent_base + ADDR_W'(mid);
            HSEL_LO:     hist_addr = ent_base + ADDR_W'(lo_reg);
            default:     hist_addr = ent_base;
        endcase
    end

    assign cnt_we     = cmd.clr_wr | cmd.cnt_inc;
    assign cnt_addr   = cmd.clr_wr ? clr_reg : ent;
    assign cnt_wdata  = cmd.clr_wr ? CNT_W'(1) : CNT_W'(cnt_q_reg + CNT_W'(1));
    assign hist_we    = cmd.clr_wr | cmd.hist_wr;
    assign hist_wdata = cmd.clr_wr ? '0 : hist_word_t'{id: current_reg, value: req_wval_reg};

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        if (cmd.cnt_rd) begin
            cnt_q_reg <= cnt_mem[ent];
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_addr] <= hist_wdata;
        end
        if (cmd.hist_rd) begin
            hist_q_reg <= hist_mem[hist_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg <= '0;
            clr_reg     <= '0;
        end else begin
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + ENT_AW'(1);
            end
            if (cmd.out_load && cmd.out_kind == RES_SNAP) begin
                current_reg <= current_reg + SNAP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_func_reg  <= s_func;
            req_idx_reg   <= s_entry_index;
            req_wval_reg  <= s_write_value;
            req_query_reg <= s_query_snapshot;
        end
        if (cmd.search_init) begin
            lo_reg <= '0;
            hi_reg <= newest;
        end else if (cmd.search_step) begin
            if (hist_q_reg.id <= req_query_reg) begin
                lo_reg <= mid;
            end else begin
                hi_reg <= mid - IDX_W'(1);
            end
        end
        if (cmd.out_load) begin
            out_value_reg  <= '0;
            out_snap_reg   <= '0;
            out_status_reg <= STATUS_OK;
            case (cmd.out_kind)
                RES_SNAP:      out_snap_reg   <= current_reg;
                RES_READ:      out_value_reg  <= hist_q_reg.value;
                RES_HIST_FULL: out_status_reg <= STATUS_HIST_FULL;
                RES_SNAP_FULL: out_status_reg <= STATUS_SNAP_FULL;
                RES_BAD_INDEX: out_status_reg <= STATUS_BAD_INDEX;
                default:       out_status_reg <= STATUS_OK;
            endcase
        end
    end

    assign sts.clr_last    = (clr_reg == ENT_AW'(ENTRIES - 1));
    assign sts.func        = req_func_reg;
    assign sts.bad_index   = (32'(req_idx_reg) >= 32'(ENTRIES));
    assign sts.snap_full   = (current_reg == SNAP_MAX);
    assign sts.id_match    = (hist_q_reg.id == current_reg);
    assign sts.hist_full   = (cnt_q_reg >= CNT_W'(HISTORY_DEPTH));
    assign sts.search_done = (lo_reg == hi_reg);

    assign m_read_value     = $signed(out_value_reg);
    assign m_taken_snapshot = out_snap_reg;
    assign m_status         = out_status_reg;

endmodule

@@ rtl/vsa_controller.sv @@
// ----------------------------------------------------------------------------
// vsa_controller
// Sequencer for clearing, request decode, write update, binary search and
// result hand-off.
// ----------------------------------------------------------------------------
module vsa_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  vsa_pkg::vsa_sts_t sts,
    output vsa_pkg::vsa_cmd_t cmd
);
    import vsa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CNT_WAIT,
        ST_WR_CHECK,
        ST_SEARCH,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.hist_sel = HSEL_LO;
        cmd.out_kind = kind_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr   = 1'b1;
                cmd.hist_sel = HSEL_CLR;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.func == FUNC_SNAP) begin
                    kind_next  = sts.snap_full ? RES_SNAP_FULL : RES_SNAP;
                    state_next = ST_FINISH;
                end else if (sts.func != FUNC_WRITE && sts.func != FUNC_READ) begin
                    kind_next  = RES_OK;
                    state_next = ST_FINISH;
                end else if (sts.bad_index) begin
                    kind_next  = RES_BAD_INDEX;
                    state_next = ST_FINISH;
                end else begin
                    cmd.cnt_rd = 1'b1;
                    state_next = ST_CNT_WAIT;
                end
            end
            ST_CNT_WAIT: begin
                if (sts.func == FUNC_WRITE) begin
                    cmd.hist_rd  = 1'b1;
                    cmd.hist_sel = HSEL_NEWEST;
                    state_next   = ST_WR_CHECK;
                end else begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end
            end
            ST_WR_CHECK: begin
                kind_next  = RES_OK;
                state_next = ST_FINISH;
                if (sts.id_match) begin
                    cmd.hist_wr  = 1'b1;
                    cmd.hist_sel = HSEL_NEWEST;
                end else if (sts.hist_full) begin
                    kind_next = RES_HIST_FULL;
                end else begin
                    cmd.hist_wr  = 1'b1;
                    cmd.hist_sel = HSEL_APPEND;
                    cmd.cnt_inc  = 1'b1;
                end
            end
            ST_SEARCH: begin
                cmd.hist_rd = 1'b1;
                if (sts.search_done) begin
                    cmd.hist_sel = HSEL_LO;
                    kind_next    = RES_READ;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.hist_sel = HSEL_MID;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.search_step = 1'b1;
                state_next      = ST_SEARCH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            kind_reg    <= RES_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/versioned_snapshot_array.sv @@
// ----------------------------------------------------------------------------
// versioned_snapshot_array
// Array of values with a bounded per-entry history of (snapshot id, value)
// pairs: write, take snapshot, and read at a snapshot id.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    func, entry_index, write_value,
//                                          query_snapshot
//   m_       out        m_valid/m_ready    read_value, taken_snapshot, status
//
// One request at a time; the next request is taken while a result waits.
// Snapshot, unused operation and bad index go straight to the result; a
// write first reads the fill count and the newest history word. A read runs
// a binary search over the entry's history, one history read per probe.
// After reset a clearing pass over all ENTRIES entries runs with s_ready low.
// A stalled result holds the block at the end of its next request.
// ----------------------------------------------------------------------------
module versioned_snapshot_array #(
    parameter int ENTRIES       = vsa_pkg::DEF_ENTRIES,
    parameter int HISTORY_DEPTH = vsa_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vsa_pkg::FUNC_W-1:0]          s_func,
    input  logic [vsa_pkg::INDEX_W-1:0]         s_entry_index,
    input  logic signed [vsa_pkg::VALUE_W-1:0]  s_write_value,
    input  logic [vsa_pkg::SNAP_W-1:0]          s_query_snapshot,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vsa_pkg::VALUE_W-1:0]  m_read_value,
    output logic [vsa_pkg::SNAP_W-1:0]          m_taken_snapshot,
    output logic [vsa_pkg::STATUS_W-1:0]        m_status
);
    import vsa_pkg::*;

    vsa_cmd_t cmd;
    vsa_sts_t sts;

    vsa_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vsa_datapath #(
        .ENTRIES       (ENTRIES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_func           (s_func),
        .s_entry_index    (s_entry_index),
        .s_write_value    (s_write_value),
        .s_query_snapshot (s_query_snapshot),
        .m_read_value     (m_read_value),
        .m_taken_snapshot (m_taken_snapshot),
        .m_status         (m_status)
    );

endmodule

@@ rtl/vsa_checker.sv @@
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks on the versioned snapshot array, bound to the top level.
// ----------------------------------------------------------------------------
module vsa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [vsa_pkg::VALUE_W-1:0]  m_read_value,
    input logic [vsa_pkg::SNAP_W-1:0]          m_taken_snapshot,
    input logic [vsa_pkg::STATUS_W-1:0]        m_status
);
    import vsa_pkg::*;

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
            && $stable(m_taken_snapshot) && $stable(m_status))
        else $error("stalled result changed");

    // drop all payload on a rejected request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_read_value == '0 && m_taken_snapshot == '0)
        else $error("rejected request carries data");

    // a snapshot id never comes with a read value or an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_taken_snapshot != '0 |-> m_status == STATUS_OK && m_read_value == '0)
        else $error("snapshot result mixed with other fields");

    // hold off requests and results right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

endmodule

bind versioned_snapshot_array vsa_checker u_vsa_checker (.*);
